[rtl/sobel_pkg.sv]
// Shared constants and helpers for the Sobel edge magnitude block.
package sobel_pkg;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int PIX_W = 24;
    localparam logic [16:0] MAG_SAT_SQ = 17'd65025;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // Square of one gradient component; |g| never exceeds 4*255, so 20 bits hold it.
    function automatic logic [19:0] grad_sq(input logic signed [11:0] g);
        logic signed [23:0] p;
        p = g * g;
        return p[19:0];
    endfunction
endpackage

[rtl/sobel_edge_magnitude_rgb.sv]
// Streaming 3x3 Sobel RGB edge magnitude, line stores in one block memory.
// Each input beat passes S_READ, S_UPD and S_EMIT; each result beat adds S_ROOT and S_OUT.
// An input beat yields up to four result beats; empty slots and m_ready stalls delay them.
// A new input beat is accepted only once the last one's result beats are issued; each
// root takes a bit per cycle.
// Reset (aresetn low, synchronous) clears counters, window and handshake, sets 640x480 size.
module sobel_edge_magnitude_rgb #(
    parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_edge_red,
    output logic [7:0]  m_edge_green,
    output logic [7:0]  m_edge_blue,
    output logic [11:0] m_pixel_row,
    output logic [10:0] m_pixel_col,
    output logic        m_last_of_run
);
    import sobel_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_UPD, S_EMIT, S_ROOT, S_OUT} state_t;

    logic [11:0] width_reg;
    logic [12:0] height_reg;
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    always_comb begin
        if (width_reg == '0) eff_w = CW'(1);
        else if (32'(width_reg) > MAX_WIDTH) eff_w = CW'(MAX_WIDTH);
        else eff_w = CW'(width_reg);
        if (height_reg == '0) eff_h = RW'(1);
        else if (32'(height_reg) > MAX_HEIGHT) eff_h = RW'(MAX_HEIGHT);
        else eff_h = RW'(height_reg);
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HEIGHT) prdata = 32'(height_reg);
        else prdata = 32'(width_reg);
    end

    // line stores: one entry holds {older, newer}
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rd;
    logic [AW-1:0]      line_addr;
    logic               line_we;
    logic [2*PIX_W-1:0] line_wd;

    always_ff @(posedge aclk) begin
        if (line_we) line_mem[line_addr] <= line_wd;
        line_rd <= line_mem[line_addr];
    end

    state_t state_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] pix_reg;
    logic [RW-1:0] r_cur_reg;
    logic [CW-1:0] c_cur_reg;
    logic [3:0] emit_mask_reg;
    logic [1:0] emit_idx_reg;
    logic [20:0] sq_reg [3];
    logic [7:0] root_reg [3];
    logic [2:0] bit_reg;

    logic [RW-1:0] r_use;
    logic [CW-1:0] c_use;
    assign r_use = (row_reg >= eff_h) ? '0 : row_reg;
    assign c_use = (col_reg >= eff_w) ? '0 : col_reg;
    assign line_addr = AW'(c_cur_reg);

    assign s_ready = (state_reg == S_IDLE) && !cfg_wr;

    logic [PIX_W-1:0] top_px, mid_px;
    assign top_px = (r_cur_reg >= RW'(2)) ? line_rd[2*PIX_W-1:PIX_W] : '0;
    assign mid_px = (r_cur_reg >= RW'(1)) ? line_rd[PIX_W-1:0] : '0;
    assign line_we = (state_reg == S_UPD);
    assign line_wd = {line_rd[PIX_W-1:0], pix_reg};

    // kernel center for current emission
    logic [1:0] cr, cc;
    always_comb begin
        cr = emit_idx_reg[1] ? 2'd2 : 2'd1;
        cc = emit_idx_reg[0] ? 2'd2 : 2'd1;
    end

    // gradient over the window around (cr, cc); positions off the window are zero
    logic [20:0] sq_sum [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic signed [11:0] gx, gy;
            logic [7:0] v;
            gx = '0;
            gy = '0;
            v = '0;
            for (int dr = -1; dr <= 1; dr++) begin
                for (int dc = -1; dc <= 1; dc++) begin
                    int wr, wc;
                    wr = int'(cr) + dr;
                    wc = int'(cc) + dc;
                    if (wr <= 2 && wc <= 2) begin
                        v = win_reg[2'(wr)][2'(wc)][16-8*ch +: 8];
                        gx = gx + 12'(dc * (dr == 0 ? 2 : 1)) * $signed({4'b0, v});
                        gy = gy + 12'(dr * (dc == 0 ? 2 : 1)) * $signed({4'b0, v});
                    end
                end
            end
            sq_sum[ch] = 21'(grad_sq(gx)) + 21'(grad_sq(gy));
        end
    end

    // one root bit per cycle, then round half up (s > n*n+n) and saturate
    logic [7:0] root_next [3];
    logic [7:0] mag [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            logic [7:0] t;
            logic [8:0] n;
            t = root_reg[ch] | (8'd1 << bit_reg);
            root_next[ch] = (21'(t) * 21'(t) <= sq_reg[ch]) ? t : root_reg[ch];
            n = {1'b0, root_reg[ch]};
            if (sq_reg[ch] > 21'(n) * 21'(n) + 21'(n)) n = n + 9'd1;
            if (sq_reg[ch] > 21'(MAG_SAT_SQ)) mag[ch] = 8'd255;
            else mag[ch] = (n > 9'd255) ? 8'd255 : n[7:0];
        end
    end

    logic [7:0] o_r_reg, o_g_reg, o_b_reg;
    logic [11:0] o_row_reg;
    logic [10:0] o_col_reg;
    logic o_last_reg, o_valid_reg;
    logic [RW-1:0] e_row;
    logic [CW-1:0] e_col;
    logic [3:0] rest_mask;
    always_comb begin
        e_row = emit_idx_reg[1] ? r_cur_reg : r_cur_reg - RW'(1);
        e_col = emit_idx_reg[0] ? c_cur_reg : c_cur_reg - CW'(1);
        rest_mask = emit_mask_reg & ~(4'b0001 << emit_idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            width_reg <= 12'd640;
            height_reg <= 13'd480;
            row_reg <= '0;
            col_reg <= '0;
            o_valid_reg <= 1'b0;
            emit_mask_reg <= '0;
            emit_idx_reg <= '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) win_reg[i][j] <= '0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_HEIGHT) height_reg <= pwdata[12:0];
                else width_reg <= pwdata[11:0];
                row_reg <= '0;
                col_reg <= '0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++) win_reg[i][j] <= '0;
            end
            // S_OUT reloads or holds the output register itself
            if (o_valid_reg && m_ready && state_reg != S_OUT) o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        pix_reg <= {s_red_in, s_green_in, s_blue_in};
                        r_cur_reg <= r_use;
                        c_cur_reg <= c_use;
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_UPD;
                S_UPD: begin
                    for (int i = 0; i < 3; i++) begin
                        win_reg[i][0] <= (c_cur_reg == '0) ? '0 : win_reg[i][1];
                        win_reg[i][1] <= (c_cur_reg == '0) ? '0 : win_reg[i][2];
                    end
                    win_reg[0][2] <= top_px;
                    win_reg[1][2] <= mid_px;
                    win_reg[2][2] <= pix_reg;
                    emit_mask_reg <= {
                        (r_cur_reg == eff_h - RW'(1)) && (c_cur_reg == eff_w - CW'(1)),
                        (r_cur_reg == eff_h - RW'(1)) && (c_cur_reg != '0),
                        (r_cur_reg != '0) && (c_cur_reg == eff_w - CW'(1)),
                        (r_cur_reg != '0) && (c_cur_reg != '0)};
                    emit_idx_reg <= '0;
                    if (c_cur_reg + CW'(1) >= eff_w) begin
                        col_reg <= '0;
                        row_reg <= (r_cur_reg + RW'(1) >= eff_h) ? '0 : r_cur_reg + RW'(1);
                    end else begin
                        col_reg <= c_cur_reg + CW'(1);
                        row_reg <= r_cur_reg;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_mask_reg == '0) state_reg <= S_IDLE;
                    else if (!emit_mask_reg[emit_idx_reg]) emit_idx_reg <= emit_idx_reg + 2'd1;
                    else begin
                        for (int ch = 0; ch < 3; ch++) begin
                            sq_reg[ch] <= sq_sum[ch];
                            root_reg[ch] <= '0;
                        end
                        bit_reg <= 3'd7;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    for (int ch = 0; ch < 3; ch++) root_reg[ch] <= root_next[ch];
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == '0) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid_reg || m_ready) begin
                        o_valid_reg <= 1'b1;
                        o_r_reg <= mag[0];
                        o_g_reg <= mag[1];
                        o_b_reg <= mag[2];
                        o_row_reg <= 12'(e_row);
                        o_col_reg <= 11'(e_col);
                        o_last_reg <= (rest_mask == '0);
                        emit_mask_reg <= rest_mask;
                        state_reg <= S_EMIT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = o_valid_reg;
    assign m_edge_red = o_r_reg;
    assign m_edge_green = o_g_reg;
    assign m_edge_blue = o_b_reg;
    assign m_pixel_row = o_row_reg;
    assign m_pixel_col = o_col_reg;
    assign m_last_of_run = o_last_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("accepted during work");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_pixel_col))
        else $error("result dropped");
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> c_cur_reg < eff_w) else $error("col out of range");
    a_mem_write: assert property (@(posedge aclk) disable iff (!aresetn)
        line_we |-> $past(state_reg) == S_READ) else $error("write without read");
endmodule
